// ===== design/preferential_attachment_graph_gen_core_assert.svh =====
// Assertion macros used by the graph generator back end.
`ifndef PREFERENTIAL_ATTACHMENT_GRAPH_GEN_CORE_ASSERT_SVH
`define PREFERENTIAL_ATTACHMENT_GRAPH_GEN_CORE_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define PAG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define PAG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pag_pkg.sv =====
// Shared constants and types of the preferential attachment graph generator.
package pag_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_LINKS_DEF = 16;

  localparam int CORE_SIZE_W   = 5;
  localparam int TOTAL_NODES_W = 11;
  localparam int CFG_DATA_W    = 11;
  localparam int CFG_IDX_W     = 1;
  localparam int SAMPLE_W      = 32;
  localparam int TOTAL_W       = 32;
  localparam int NODE_W        = 10;
  localparam int STATUS_W      = 2;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CORE_SIZE_W-1:0]   CORE_SIZE_RST   = 5'd2;
  localparam logic [TOTAL_NODES_W-1:0] TOTAL_NODES_RST = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_CORE_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_NODES = 1'b1;

  typedef enum logic [0:0] {
    CMD_START  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_EDGE    = 2'd0,
    ST_PENDING = 2'd1,
    ST_DUP     = 2'd2,
    ST_DONE    = 2'd3
  } status_e;

endpackage

// ===== design/pag_front.sv =====
// Front end: configuration registers, input beat acceptance and command classification.
module pag_front #(
  parameter int MaxNodes = pag_pkg::MAX_NODES_DEF,
  parameter int MaxLinks = pag_pkg::MAX_LINKS_DEF,
  localparam int CntW    = $clog2(MaxNodes + 1),
  localparam int LinkW   = $clog2(MaxLinks + 1),
  localparam int EntryW  = 1 + pag_pkg::SAMPLE_W + LinkW + CntW
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pag_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pag_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [pag_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output logic [EntryW-1:0]              q_data_o
);

  // Links per node are capped by the target storage and by the node space.
  localparam int LinkCap = (MaxLinks < MaxNodes - 1) ? MaxLinks : MaxNodes - 1;

  logic [pag_pkg::CORE_SIZE_W-1:0]   core_size_q;
  logic [pag_pkg::TOTAL_NODES_W-1:0] total_nodes_q;
  logic [LinkW-1:0]                  links;
  logic [CntW-1:0]                   limit;
  pag_pkg::cmd_e                     cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_size_q   <= pag_pkg::CORE_SIZE_RST;
      total_nodes_q <= pag_pkg::TOTAL_NODES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pag_pkg::CFG_CORE_SIZE: begin
          core_size_q <= cfg_data_i[pag_pkg::CORE_SIZE_W-1:0];
        end
        pag_pkg::CFG_TOTAL_NODES: begin
          total_nodes_q <= cfg_data_i[pag_pkg::TOTAL_NODES_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (core_size_q == '0) begin
      links = LinkW'(1);
    end else if (int'(core_size_q) > LinkCap) begin
      links = LinkW'(LinkCap);
    end else begin
      links = LinkW'(core_size_q);
    end
    if (int'(total_nodes_q) > MaxNodes) begin
      limit = CntW'(MaxNodes);
    end else begin
      limit = CntW'(total_nodes_q);
    end
    cmd = kind_i ? pag_pkg::CMD_SAMPLE : pag_pkg::CMD_START;
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign q_data_o   = {cmd, sample_i, links, limit};

endmodule

// ===== design/pag_queue.sv =====
// Short command queue between the front end and the back end.
module pag_queue #(
  parameter int Width = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int Depth = pag_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/pag_back.sv =====
// Back end: graph state, degree memory, roulette walk, duplicate check and edge emission.
`include "preferential_attachment_graph_gen_core_assert.svh"

module pag_back #(
  parameter int MaxNodes = pag_pkg::MAX_NODES_DEF,
  parameter int MaxLinks = pag_pkg::MAX_LINKS_DEF,
  localparam int CntW    = $clog2(MaxNodes + 1),
  localparam int LinkW   = $clog2(MaxLinks + 1),
  localparam int EntryW  = 1 + pag_pkg::SAMPLE_W + LinkW + CntW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  output logic                         q_pop_o,
  input  logic [EntryW-1:0]            q_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pag_pkg::STATUS_W-1:0] status_o,
  output logic [pag_pkg::NODE_W-1:0]   source_node_o,
  output logic [pag_pkg::NODE_W-1:0]   dest_node_o,
  output logic                         last_o
);

  localparam int IdxW    = $clog2(MaxNodes);
  localparam int LIdxW   = (MaxLinks > 1) ? $clog2(MaxLinks) : 1;
  localparam int DegW    = $clog2(MaxNodes + MaxLinks + 1);
  localparam int SampleW = pag_pkg::SAMPLE_W;
  localparam int TotalW  = pag_pkg::TOTAL_W;
  localparam int NodeW   = pag_pkg::NODE_W;
  localparam int ProdW   = SampleW + TotalW;
  localparam int CeilW   = TotalW + 1;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DECODE = 11'b000_0000_0010,
    S_CORE   = 11'b000_0000_0100,
    S_CFIN   = 11'b000_0000_1000,
    S_MUL    = 11'b000_0001_0000,
    S_CEIL   = 11'b000_0010_0000,
    S_WALK   = 11'b000_0100_0000,
    S_DUP    = 11'b000_1000_0000,
    S_SEL    = 11'b001_0000_0000,
    S_INC    = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Command taken from the queue.
  logic [0:0]         ent_cmd;
  logic [SampleW-1:0] ent_sample;
  logic [LinkW-1:0]   ent_links;
  logic [CntW-1:0]    ent_limit;
  pag_pkg::cmd_e      cmd_q;
  logic [SampleW-1:0] sample_q;
  logic [LinkW-1:0]   ent_links_q;
  logic [CntW-1:0]    limit_q;

  // Graph state.
  logic               running_q, running_d;
  logic [LinkW-1:0]   links_q, links_d;
  logic [CntW-1:0]    node_count_q, node_count_d;
  logic [TotalW-1:0]  total_q, total_d;
  logic [LinkW-1:0]   chosen_cnt_q, chosen_cnt_d;
  logic               zero_q, zero_d;

  // Walk and selection working registers.
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [CeilW-1:0]   ceil_q, ceil_d;
  logic [TotalW-1:0]  sum_q, sum_d, sum_nx;
  logic [CntW-1:0]    addr_q, addr_d;
  logic               dvld_q, dvld_d;
  logic [IdxW-1:0]    didx_q, didx_d;
  logic [IdxW-1:0]    pick_q, pick_d;
  logic [LinkW-1:0]   scan_q, scan_d;
  logic [LinkW-1:0]   emit_k_q, emit_k_d;
  logic [IdxW-1:0]    best_q, best_d;
  logic               best_vld_q, best_vld_d;
  logic [IdxW-1:0]    prev_q, prev_d;
  logic               prev_vld_q, prev_vld_d;
  logic               hit, issue, cand, k_last;
  logic [LinkW-1:0]   cnt_nx;

  // Degree memory and chosen target registers.
  logic [DegW-1:0]    deg_mem [MaxNodes];
  logic               mem_we, mem_re;
  logic [IdxW-1:0]    mem_waddr, mem_raddr;
  logic [DegW-1:0]    mem_wdata, mem_rdata_q;
  logic [IdxW-1:0]    chosen_q [MaxLinks];
  logic               ch_we;
  logic [LIdxW-1:0]   ch_waddr;
  logic [IdxW-1:0]    ch_rdata;

  // Result register.
  logic               out_free, emit, emit_last;
  pag_pkg::status_e   emit_status;
  logic [NodeW-1:0]   emit_src, emit_dst;
  logic               out_valid_q;
  pag_pkg::status_e   status_q;
  logic [NodeW-1:0]   src_q, dst_q;
  logic               last_q;

  assign {ent_cmd, ent_sample, ent_links, ent_limit} = q_data_i;

  assign out_free = !out_valid_q || !out_stall_i;
  assign ch_rdata = chosen_q[scan_q[LIdxW-1:0]];
  assign sum_nx   = sum_q + TotalW'(mem_rdata_q);
  assign hit      = dvld_q && ({1'b0, sum_nx} >= ceil_q);
  assign issue    = addr_q < node_count_q;
  assign cand     = (!prev_vld_q || ch_rdata > prev_q) && (!best_vld_q || ch_rdata < best_q);
  assign k_last   = (emit_k_q + LinkW'(1)) == links_q;
  assign cnt_nx   = chosen_cnt_q + LinkW'(1);

  always_comb begin
    state_d      = state_q;
    running_d    = running_q;
    links_d      = links_q;
    node_count_d = node_count_q;
    total_d      = total_q;
    chosen_cnt_d = chosen_cnt_q;
    zero_d       = zero_q;
    prod_d       = prod_q;
    ceil_d       = ceil_q;
    sum_d        = sum_q;
    addr_d       = addr_q;
    dvld_d       = dvld_q;
    didx_d       = didx_q;
    pick_d       = pick_q;
    scan_d       = scan_q;
    emit_k_d     = emit_k_q;
    best_d       = best_q;
    best_vld_d   = best_vld_q;
    prev_d       = prev_q;
    prev_vld_d   = prev_vld_q;
    q_pop_o      = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    ch_we        = 1'b0;
    ch_waddr     = chosen_cnt_q[LIdxW-1:0];
    emit         = 1'b0;
    emit_status  = pag_pkg::ST_DONE;
    emit_src     = '0;
    emit_dst     = '0;
    emit_last    = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        if (cmd_q == pag_pkg::CMD_START) begin
          if (CntW'(ent_links_q) >= limit_q) begin
            // The core alone already fills the graph.
            if (out_free) begin
              emit         = 1'b1;
              running_d    = 1'b1;
              links_d      = ent_links_q;
              chosen_cnt_d = '0;
              total_d      = '0;
              node_count_d = CntW'(ent_links_q);
              emit_k_d     = '0;
              zero_d       = 1'b1;
              state_d      = S_CORE;
            end
          end else begin
            running_d    = 1'b1;
            links_d      = ent_links_q;
            chosen_cnt_d = '0;
            total_d      = '0;
            node_count_d = CntW'(ent_links_q);
            emit_k_d     = '0;
            state_d      = S_CORE;
          end
        end else if (!running_q || node_count_q >= limit_q) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_MUL;
        end
      end

      S_CORE: begin
        if (zero_q) begin
          // A graph complete at its start keeps a zero-degree core, should the limit rise later.
          mem_we    = 1'b1;
          mem_waddr = IdxW'(emit_k_q);
          mem_wdata = '0;
          emit_k_d  = emit_k_q + LinkW'(1);
          if (k_last) begin
            zero_d  = 1'b0;
            state_d = S_IDLE;
          end
        end else if (out_free) begin
          // The first new node links to every core node, one beat per edge.
          emit        = 1'b1;
          emit_status = pag_pkg::ST_EDGE;
          emit_src    = NodeW'(links_q);
          emit_dst    = NodeW'(emit_k_q);
          emit_last   = k_last;
          mem_we      = 1'b1;
          mem_waddr   = IdxW'(emit_k_q);
          mem_wdata   = DegW'(1);
          emit_k_d    = emit_k_q + LinkW'(1);
          if (k_last) begin
            state_d = S_CFIN;
          end
        end
      end

      S_CFIN: begin
        mem_we       = 1'b1;
        mem_waddr    = IdxW'(links_q);
        mem_wdata    = DegW'(links_q);
        node_count_d = CntW'(links_q) + CntW'(1);
        total_d      = TotalW'({links_q, 1'b0});
        state_d      = S_IDLE;
      end

      S_MUL: begin
        prod_d  = ProdW'(sample_q) * ProdW'(total_q);
        state_d = S_CEIL;
      end

      S_CEIL: begin
        // sum * 2^32 >= product holds exactly when sum >= ceil(product / 2^32).
        ceil_d  = CeilW'(prod_q[ProdW-1:SampleW]) + CeilW'(|prod_q[SampleW-1:0]);
        sum_d   = '0;
        addr_d  = '0;
        dvld_d  = 1'b0;
        state_d = S_WALK;
      end

      S_WALK: begin
        // Reads are issued one per cycle; the registered data returns in the cycle after its read.
        if (dvld_q) begin
          sum_d = sum_nx;
        end
        if (hit) begin
          pick_d  = didx_q;
          dvld_d  = 1'b0;
          scan_d  = '0;
          state_d = S_DUP;
        end else if (issue) begin
          mem_re    = 1'b1;
          mem_raddr = addr_q[IdxW-1:0];
          dvld_d    = 1'b1;
          didx_d    = addr_q[IdxW-1:0];
          addr_d    = addr_q + CntW'(1);
        end else if (!dvld_q) begin
          // No node qualified: fall back to the last node present.
          pick_d  = IdxW'(node_count_q - CntW'(1));
          scan_d  = '0;
          state_d = S_DUP;
        end else begin
          dvld_d = 1'b0;
        end
      end

      S_DUP: begin
        if (scan_q < chosen_cnt_q) begin
          if (ch_rdata == pick_q) begin
            if (out_free) begin
              emit        = 1'b1;
              emit_status = pag_pkg::ST_DUP;
              emit_src    = NodeW'(node_count_q);
              emit_dst    = NodeW'(pick_q);
              state_d     = S_IDLE;
            end
          end else begin
            scan_d = scan_q + LinkW'(1);
          end
        end else if (cnt_nx < links_q) begin
          if (out_free) begin
            emit         = 1'b1;
            emit_status  = pag_pkg::ST_PENDING;
            emit_src     = NodeW'(node_count_q);
            emit_dst     = NodeW'(pick_q);
            ch_we        = 1'b1;
            chosen_cnt_d = cnt_nx;
            state_d      = S_IDLE;
          end
        end else begin
          ch_we        = 1'b1;
          chosen_cnt_d = cnt_nx;
          scan_d       = '0;
          emit_k_d     = '0;
          prev_vld_d   = 1'b0;
          best_vld_d   = 1'b0;
          state_d      = S_SEL;
        end
      end

      S_SEL: begin
        // Find the smallest chosen target above the one emitted last.
        if (scan_q < links_q) begin
          if (cand) begin
            best_d     = ch_rdata;
            best_vld_d = 1'b1;
          end
          scan_d = scan_q + LinkW'(1);
        end else begin
          mem_re    = 1'b1;
          mem_raddr = best_q;
          state_d   = S_INC;
        end
      end

      S_INC: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = pag_pkg::ST_EDGE;
          emit_src    = NodeW'(node_count_q);
          emit_dst    = NodeW'(best_q);
          emit_last   = k_last;
          mem_we      = 1'b1;
          mem_waddr   = best_q;
          mem_wdata   = mem_rdata_q + DegW'(1);
          emit_k_d    = emit_k_q + LinkW'(1);
          prev_d      = best_q;
          prev_vld_d  = 1'b1;
          best_vld_d  = 1'b0;
          scan_d      = '0;
          state_d     = k_last ? S_FIN : S_SEL;
        end
      end

      S_FIN: begin
        mem_we       = 1'b1;
        mem_waddr    = node_count_q[IdxW-1:0];
        mem_wdata    = DegW'(links_q);
        total_d      = total_q + TotalW'({links_q, 1'b0});
        node_count_d = node_count_q + CntW'(1);
        chosen_cnt_d = '0;
        state_d      = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      running_q    <= 1'b0;
      links_q      <= '0;
      node_count_q <= '0;
      total_q      <= '0;
      chosen_cnt_q <= '0;
      zero_q       <= 1'b0;
      dvld_q       <= 1'b0;
      scan_q       <= '0;
      emit_k_q     <= '0;
      best_vld_q   <= 1'b0;
      prev_vld_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      running_q    <= running_d;
      links_q      <= links_d;
      node_count_q <= node_count_d;
      total_q      <= total_d;
      chosen_cnt_q <= chosen_cnt_d;
      zero_q       <= zero_d;
      dvld_q       <= dvld_d;
      scan_q       <= scan_d;
      emit_k_q     <= emit_k_d;
      best_vld_q   <= best_vld_d;
      prev_vld_q   <= prev_vld_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q       <= pag_pkg::cmd_e'(ent_cmd);
      sample_q    <= ent_sample;
      ent_links_q <= ent_links;
      limit_q     <= ent_limit;
    end
    prod_q <= prod_d;
    ceil_q <= ceil_d;
    sum_q  <= sum_d;
    addr_q <= addr_d;
    didx_q <= didx_d;
    pick_q <= pick_d;
    best_q <= best_d;
    prev_q <= prev_d;
    if (emit) begin
      status_q <= emit_status;
      src_q    <= emit_src;
      dst_q    <= emit_dst;
      last_q   <= emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      deg_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= deg_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ch_we) begin
      chosen_q[ch_waddr] <= pick_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign source_node_o = src_q;
  assign dest_node_o   = dst_q;
  assign last_o        = last_q;

  `PAG_ASSERT_IMP(a_emit_room, emit, !out_valid_q || !out_stall_i, "result beat would overwrite a pending one")
  `PAG_ASSERT_IMP(a_chosen_bound, running_q && (state_q == S_IDLE || state_q == S_DUP || state_q == S_WALK), chosen_cnt_q < links_q, "chosen target count reached the link count outside emission")
  `PAG_ASSERT_IMP(a_pick_range, state_q == S_DUP, CntW'(pick_q) < node_count_q, "picked node lies beyond the graph")
  `PAG_ASSERT_NXT(a_node_step, state_q == S_FIN, node_count_q == $past(node_count_q) + CntW'(1), "node count did not advance after a completed node")
  `PAG_ASSERT_IMP(a_total_even, running_q, !total_q[0], "degree total became odd")

endmodule

// ===== design/preferential_attachment_graph_gen_core.sv =====
// Top level of the preferential attachment graph generator.
// A start beat is popped and decoded, then emits one edge beat per core node and finally
// writes the first new node's degree. A start whose core already fills the graph answers
// with one done beat and then zeroes the core's degree entries.
// A sample beat runs the roulette walk, which reads the degree memory through its single
// read port at one entry per cycle (up to MaxNodes reads), followed by a duplicate scan
// over the chosen targets. The sample that completes a node then emits its edges in
// ascending order of target; each edge scans all chosen targets and then updates one
// degree entry. Beats beyond the first are held in a two-entry queue, and a finished
// result waits in an output register. The degree memory is never cleared after reset:
// every entry below the node count is rewritten after each start, so generation may
// begin right after reset.
module preferential_attachment_graph_gen_core #(
  parameter int MaxNodes = pag_pkg::MAX_NODES_DEF,
  parameter int MaxLinks = pag_pkg::MAX_LINKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pag_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pag_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [pag_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pag_pkg::STATUS_W-1:0]   status_o,
  output logic [pag_pkg::NODE_W-1:0]     source_node_o,
  output logic [pag_pkg::NODE_W-1:0]     dest_node_o,
  output logic                           last_o
);

  localparam int CntW   = $clog2(MaxNodes + 1);
  localparam int LinkW  = $clog2(MaxLinks + 1);
  localparam int EntryW = 1 + pag_pkg::SAMPLE_W + LinkW + CntW;

  logic              q_full, q_push, q_empty, q_pop;
  logic [EntryW-1:0] q_wdata, q_rdata;

  pag_front #(
    .MaxNodes (MaxNodes),
    .MaxLinks (MaxLinks)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .sample_i    (sample_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  pag_queue #(
    .Width (EntryW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  pag_back #(
    .MaxNodes (MaxNodes),
    .MaxLinks (MaxLinks)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .q_data_i      (q_rdata),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .source_node_o (source_node_o),
    .dest_node_o   (dest_node_o),
    .last_o        (last_o)
  );

endmodule
